>>> rtl/core/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// Shared constants, register map and types of the sensor alert controller
// register block.
// ----------------------------------------------------------------------------
`default_nettype none

package sac_pkg;

  // sizing
  localparam int SENSOR_COUNT = 11;
  localparam int PAD_COUNT    = 4;

  // payload widths
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 2;
  localparam int IDX_W   = 5;
  localparam int OFF_W   = 2;
  localparam int SIZE_W  = 3;
  localparam int EVENT_W = 4;
  localparam int INTR_W  = 2;
  localparam int ALERT_W = 2;
  localparam int MUBI_W  = 4;
  localparam int PAD_W   = 8;
  localparam int STAT_W  = 3;

  // register map (word index)
  localparam int RI_INTR_STATE  = 0;
  localparam int RI_INTR_ENABLE = 1;
  localparam int RI_INTR_TEST   = 2;
  localparam int RI_ALERT_TEST  = 3;
  localparam int RI_CFG_REGWEN  = 4;
  localparam int RI_ALERT_TRIG  = 5;
  localparam int RI_ALERT_EN    = 6;
  localparam int RI_FATAL_EN    = 6 + SENSOR_COUNT;
  localparam int RI_RECOV       = 7 + SENSOR_COUNT;
  localparam int RI_FATAL       = 8 + SENSOR_COUNT;
  localparam int RI_STATUS      = 9 + SENSOR_COUNT;
  localparam int RI_PAD_REGWEN  = 10 + SENSOR_COUNT;
  localparam int RI_PAD_ATTR    = 10 + SENSOR_COUNT + PAD_COUNT;
  localparam int REG_COUNT      = 10 + SENSOR_COUNT + 2 * PAD_COUNT;

  // field codes and reset values
  localparam logic [MUBI_W-1:0] MUBI4_FALSE    = 4'h9;
  localparam logic [MUBI_W-1:0] ALERT_EN_RESET = 4'h6;
  localparam logic [PAD_W-1:0]  PAD_ATTR_MASK  = 8'h8C;
  localparam logic [STAT_W-1:0] STATUS_VALUE   = 3'h7;

  typedef logic [SENSOR_COUNT-1:0] sensor_vec_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_EVENT = 2'd2
  } kind_t;

  // one request
  typedef struct packed {
    kind_t               kind;
    logic [IDX_W-1:0]    reg_index;
    logic [OFF_W-1:0]    byte_offset;
    logic [SIZE_W-1:0]   access_size;
    logic [DATA_W-1:0]   write_data;
    logic [EVENT_W-1:0]  event_index;
  } req_t;

  // one result
  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic                access_rejected;
    logic [INTR_W-1:0]   intr_lines;
    logic [ALERT_W-1:0]  alert_lines;
    logic [ALERT_W-1:0]  alert_pulse;
    logic                wakeup;
  } rsp_t;

  // alert evaluation inputs
  typedef struct packed {
    sensor_vec_t latch;
    sensor_vec_t trigger;
    sensor_vec_t enabled;
    sensor_vec_t fatal_sel;
    sensor_vec_t recov;
    sensor_vec_t fatal;
  } alert_in_t;

  // alert evaluation outputs
  typedef struct packed {
    sensor_vec_t        latch;
    sensor_vec_t        recov;
    sensor_vec_t        fatal;
    logic [ALERT_W-1:0] level;
    logic [ALERT_W-1:0] pulse;
    logic               wake;
  } alert_out_t;

endpackage

`default_nettype wire

>>> rtl/core/sac_if.sv
// ----------------------------------------------------------------------------
// sac_if
// Valid/ready channels of the register block: request in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sac_req_if
  import sac_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [IDX_W-1:0]   reg_index;
  logic [OFF_W-1:0]   byte_offset;
  logic [SIZE_W-1:0]  access_size;
  logic [DATA_W-1:0]  write_data;
  logic [EVENT_W-1:0] event_index;

  modport source (
    output valid, kind, reg_index, byte_offset, access_size, write_data, event_index,
    input  ready
  );
  modport sink (
    input  valid, kind, reg_index, byte_offset, access_size, write_data, event_index,
    output ready
  );
endinterface

interface sac_rsp_if
  import sac_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  read_data;
  logic               access_rejected;
  logic [INTR_W-1:0]  intr_lines;
  logic [ALERT_W-1:0] alert_lines;
  logic [ALERT_W-1:0] alert_pulse;
  logic               wakeup;

  modport source (
    output valid, read_data, access_rejected, intr_lines, alert_lines, alert_pulse, wakeup,
    input  ready
  );
  modport sink (
    input  valid, read_data, access_rejected, intr_lines, alert_lines, alert_pulse, wakeup,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/sac_alert_eval.sv
// ----------------------------------------------------------------------------
// sac_alert_eval
// Alert refresh: latches triggers, splits enabled events into recoverable
// and fatal records, drops recorded recoverable events, derives lines.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_alert_eval
  import sac_pkg::*;
(
  input  alert_in_t  ain,
  output alert_out_t aout
);

  sensor_vec_t latch_all;
  sensor_vec_t active;
  sensor_vec_t recov_hit;

  // active events and their split
  assign latch_all = ain.latch | ain.trigger;
  assign active    = latch_all & ain.enabled;
  assign recov_hit = active & ~ain.fatal_sel;

  // sticky records, recorded recoverable events leave unless still triggered
  always_comb begin
    aout.recov = ain.recov | recov_hit;
    aout.fatal = ain.fatal | (active & ain.fatal_sel);
    aout.latch = latch_all & ~(recov_hit & ~ain.trigger);
    aout.pulse = {|aout.fatal, |recov_hit};
    aout.level = {|aout.fatal, |(recov_hit & ain.trigger)};
    aout.wake  = (|(aout.latch & ain.enabled)) || (|aout.recov);
  end

endmodule

`default_nettype wire

>>> rtl/core/sac_regs.sv
// ----------------------------------------------------------------------------
// sac_regs
// Register file and access decode: applies one request to the state and
// forms its result in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_regs
  import sac_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  req_t req,
  output rsp_t rsp
);

  // state
  logic [INTR_W-1:0]  intr_state_r, intr_state_nxt;
  logic [INTR_W-1:0]  intr_enable_r, intr_enable_nxt;
  logic               cfg_unl_r, cfg_unl_nxt;
  sensor_vec_t        trig_r, trig_nxt;
  logic [MUBI_W-1:0]  alert_en_r [SENSOR_COUNT];
  logic [MUBI_W-1:0]  alert_en_nxt [SENSOR_COUNT];
  sensor_vec_t        fsel_r, fsel_nxt;
  sensor_vec_t        recov_r, recov_nxt;
  sensor_vec_t        fatal_r, fatal_nxt;
  sensor_vec_t        latch_r, latch_nxt;
  logic [PAD_W-1:0]   pad_attr_r [PAD_COUNT];
  logic [PAD_W-1:0]   pad_attr_nxt [PAD_COUNT];
  logic [PAD_COUNT-1:0] pad_unl_r, pad_unl_nxt;
  logic [ALERT_W-1:0] level_r, level_nxt;
  logic               wake_r, wake_nxt;

  // decode
  logic               is_read, wr_req, in_range, need_hi, be_ok, wr_ok;
  logic [8:0]         size_mask;
  logic [10:0]        be;
  logic               refresh;
  logic [ALERT_W-1:0] test_bits;
  sensor_vec_t        wr_sens;
  sensor_vec_t        ev_bit;
  sensor_vec_t        latch_pre;
  sensor_vec_t        recov_pre;
  sensor_vec_t        en_mask;
  logic [DATA_W-1:0]  rdata;
  alert_in_t          ain;
  alert_out_t         aout;

  assign is_read  = (req.kind == KIND_READ);
  assign wr_req   = (req.kind == KIND_WRITE);
  assign in_range = (int'(req.reg_index) < REG_COUNT);
  assign wr_sens  = req.write_data[SENSOR_COUNT-1:0];

  // byte-enable acceptance
  assign size_mask = (9'd1 << req.access_size) - 9'd1;
  assign be        = {2'b00, size_mask} << req.byte_offset;
  assign need_hi   = (int'(req.reg_index) == RI_ALERT_TRIG) ||
                     (int'(req.reg_index) == RI_FATAL_EN) ||
                     (int'(req.reg_index) == RI_RECOV) ||
                     (int'(req.reg_index) == RI_FATAL);
  assign be_ok     = be[0] && (!need_hi || be[1]);
  assign wr_ok     = wr_req && in_range && be_ok;

  // event bit for an injection in range
  always_comb begin
    ev_bit = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (req.kind == KIND_EVENT && int'(req.event_index) == i) ev_bit[i] = 1'b1;
    end
  end

  // register writes
  always_comb begin
    intr_state_nxt  = intr_state_r;
    intr_enable_nxt = intr_enable_r;
    cfg_unl_nxt     = cfg_unl_r;
    trig_nxt        = trig_r;
    fsel_nxt        = fsel_r;
    recov_pre       = recov_r;
    pad_unl_nxt     = pad_unl_r;
    refresh         = |ev_bit;
    test_bits       = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) alert_en_nxt[i] = alert_en_r[i];
    for (int p = 0; p < PAD_COUNT; p++) pad_attr_nxt[p] = pad_attr_r[p];
    if (wr_ok) begin
      if (int'(req.reg_index) == RI_INTR_STATE)
        intr_state_nxt = intr_state_r & ~req.write_data[INTR_W-1:0];
      if (int'(req.reg_index) == RI_INTR_ENABLE)
        intr_enable_nxt = req.write_data[INTR_W-1:0];
      if (int'(req.reg_index) == RI_INTR_TEST)
        intr_state_nxt = intr_state_r | req.write_data[INTR_W-1:0];
      if (int'(req.reg_index) == RI_ALERT_TEST) begin
        test_bits = req.write_data[ALERT_W-1:0];
        refresh   = 1'b1;
      end
      if (int'(req.reg_index) == RI_CFG_REGWEN)
        cfg_unl_nxt = cfg_unl_r & req.write_data[0];
      if (int'(req.reg_index) == RI_ALERT_TRIG) begin
        trig_nxt = wr_sens;
        refresh  = 1'b1;
      end
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if (int'(req.reg_index) == RI_ALERT_EN + i && cfg_unl_r) begin
          alert_en_nxt[i] = req.write_data[MUBI_W-1:0];
          refresh         = 1'b1;
        end
      end
      if (int'(req.reg_index) == RI_FATAL_EN && cfg_unl_r) begin
        fsel_nxt = wr_sens;
        refresh  = 1'b1;
      end
      if (int'(req.reg_index) == RI_RECOV) begin
        recov_pre = recov_r & ~wr_sens;
        refresh   = 1'b1;
      end
      for (int p = 0; p < PAD_COUNT; p++) begin
        if (int'(req.reg_index) == RI_PAD_REGWEN + p)
          pad_unl_nxt[p] = pad_unl_r[p] & req.write_data[0];
        if (int'(req.reg_index) == RI_PAD_ATTR + p && pad_unl_r[p])
          pad_attr_nxt[p] = req.write_data[PAD_W-1:0] & PAD_ATTR_MASK;
      end
    end
  end

  // enabled sensors after this request
  always_comb begin
    for (int i = 0; i < SENSOR_COUNT; i++) en_mask[i] = (alert_en_nxt[i] != MUBI4_FALSE);
  end

  assign latch_pre = latch_r | ev_bit;

  always_comb begin
    ain.latch     = latch_pre;
    ain.trigger   = trig_nxt;
    ain.enabled   = en_mask;
    ain.fatal_sel = fsel_nxt;
    ain.recov     = recov_pre;
    ain.fatal     = fatal_r;
  end

  sac_alert_eval u_alert (
    .ain  (ain),
    .aout (aout)
  );

  // alert state follows the refresh only when one runs
  assign latch_nxt = refresh ? aout.latch : latch_pre;
  assign recov_nxt = refresh ? aout.recov : recov_pre;
  assign fatal_nxt = refresh ? aout.fatal : fatal_r;
  assign level_nxt = refresh ? aout.level : level_r;
  assign wake_nxt  = refresh ? aout.wake  : wake_r;

  // read mux
  always_comb begin
    rdata = '0;
    if (int'(req.reg_index) == RI_INTR_STATE)
      rdata = DATA_W'(intr_state_r);
    if (int'(req.reg_index) == RI_INTR_ENABLE)
      rdata = DATA_W'(intr_enable_r);
    if (int'(req.reg_index) == RI_CFG_REGWEN)
      rdata = DATA_W'(cfg_unl_r);
    if (int'(req.reg_index) == RI_ALERT_TRIG)
      rdata = DATA_W'(trig_r);
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (int'(req.reg_index) == RI_ALERT_EN + i) rdata = DATA_W'(alert_en_r[i]);
    end
    if (int'(req.reg_index) == RI_FATAL_EN)
      rdata = DATA_W'(fsel_r);
    if (int'(req.reg_index) == RI_RECOV)
      rdata = DATA_W'(recov_r);
    if (int'(req.reg_index) == RI_FATAL)
      rdata = DATA_W'(fatal_r);
    if (int'(req.reg_index) == RI_STATUS)
      rdata = DATA_W'(STATUS_VALUE);
    for (int p = 0; p < PAD_COUNT; p++) begin
      if (int'(req.reg_index) == RI_PAD_REGWEN + p) rdata = DATA_W'(pad_unl_r[p]);
      if (int'(req.reg_index) == RI_PAD_ATTR + p) rdata = DATA_W'(pad_attr_r[p]);
    end
  end

  // result of this request
  always_comb begin
    rsp.read_data       = (is_read && in_range) ? rdata : '0;
    rsp.access_rejected = (is_read && !in_range) || (wr_req && !(in_range && be_ok));
    rsp.intr_lines      = intr_state_nxt & intr_enable_nxt;
    rsp.alert_lines     = level_nxt;
    rsp.alert_pulse     = level_r | (refresh ? (aout.pulse | test_bits) : '0);
    rsp.wakeup          = wake_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intr_state_r  <= '0;
      intr_enable_r <= '0;
      cfg_unl_r     <= 1'b1;
      trig_r        <= '0;
      fsel_r        <= '0;
      recov_r       <= '0;
      fatal_r       <= '0;
      latch_r       <= '0;
      pad_unl_r     <= '1;
      level_r       <= '0;
      wake_r        <= 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) alert_en_r[i] <= ALERT_EN_RESET;
      for (int p = 0; p < PAD_COUNT; p++) pad_attr_r[p] <= '0;
    end else if (fire) begin
      intr_state_r  <= intr_state_nxt;
      intr_enable_r <= intr_enable_nxt;
      cfg_unl_r     <= cfg_unl_nxt;
      trig_r        <= trig_nxt;
      fsel_r        <= fsel_nxt;
      recov_r       <= recov_nxt;
      fatal_r       <= fatal_nxt;
      latch_r       <= latch_nxt;
      pad_unl_r     <= pad_unl_nxt;
      level_r       <= level_nxt;
      wake_r        <= wake_nxt;
      for (int i = 0; i < SENSOR_COUNT; i++) alert_en_r[i] <= alert_en_nxt[i];
      for (int p = 0; p < PAD_COUNT; p++) pad_attr_r[p] <= pad_attr_nxt[p];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sensor_alert_controller_regs_core.sv
// ----------------------------------------------------------------------------
// sensor_alert_controller_regs_core
// Sensor alert controller register block: bus reads, bus writes and sensor
// events in, one result per request out.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    kind, reg_index, byte_offset, access_size,
//                                write_data, event_index
//   out_ch   out  valid/ready    read_data, access_rejected, intr_lines,
//                                alert_lines, alert_pulse, wakeup
//
// One request per cycle sustained while out_ch is ready; the result is registered
// (input register, then register update and result register). The register
// update is one pass of masking logic in sac_regs.
// rst_n resets all control and register state synchronously.
// A stalled result holds in the output register; the input register takes
// its request into the register file as soon as the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_alert_controller_regs_core
  import sac_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  sac_req_if.sink        in_ch,
  sac_rsp_if.source      out_ch
);

  logic s1_valid_r, s1_valid_nxt;
  req_t s1_req_r;
  req_t in_req;
  logic s1_adv;
  logic out_valid_r, out_valid_nxt;
  rsp_t out_rsp_r;
  rsp_t rsp;

  // request register
  always_comb begin
    in_req.kind        = kind_t'(in_ch.kind);
    in_req.reg_index   = in_ch.reg_index;
    in_req.byte_offset = in_ch.byte_offset;
    in_req.access_size = in_ch.access_size;
    in_req.write_data  = in_ch.write_data;
    in_req.event_index = in_ch.event_index;
  end

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ch.valid && in_ch.ready) s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) s1_req_r <= in_req;
  end

  // register file and decode
  sac_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_adv),
    .req   (s1_req_r),
    .rsp   (rsp)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_rsp_r <= rsp;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.read_data       = out_rsp_r.read_data;
  assign out_ch.access_rejected = out_rsp_r.access_rejected;
  assign out_ch.intr_lines      = out_rsp_r.intr_lines;
  assign out_ch.alert_lines     = out_rsp_r.alert_lines;
  assign out_ch.alert_pulse     = out_rsp_r.alert_pulse;
  assign out_ch.wakeup          = out_rsp_r.wakeup;

  // checks
  a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |=> s1_valid_r)
    else $error("pending request dropped while result stalled");

  a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result register not filled after advance");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("input not ready with empty request register");

  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(out_rsp_r))
    else $error("stalled result changed");

endmodule

`default_nettype wire
